FILE: hdl/lsau_pkg.sv
// Shared types and constants for the load/store address unit.
// Used by lsau_regfile, lsau_exec and load_store_address_unit; depends on nothing.
package lsau_pkg;

    localparam int XLEN     = 64;
    localparam int NUM_REGS = 31;

    localparam logic [4:0] ZERO_REG = 5'd31;

    // Item actions
    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_RETURN = 2'd1;
    localparam logic [1:0] ACT_WRITE  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_MEM_RD  = 2'd1;
    localparam logic [1:0] KIND_MEM_WR  = 2'd2;
    localparam logic [1:0] KIND_REG_RPL = 2'd3;

    typedef struct packed {
        logic [1:0]      action;
        logic [31:0]     word;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] ret_data;
        logic [4:0]      sel;
        logic [XLEN-1:0] wr_value;
    } t_item;

    typedef struct packed {
        logic            en;
        logic [4:0]      addr;
        logic [XLEN-1:0] data;
    } t_reg_wr;

    typedef struct packed {
        logic [1:0]      kind;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] data;
        logic            wide;
        logic            unsup;
    } t_result;

endpackage

FILE: hdl/lsau_regfile.sv
// Register file X0..X30: two synchronous memory copies with registered reads,
// per-entry valid bits, last-write forwarding and the zero register. Uses lsau_pkg.
module lsau_regfile
    import lsau_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [4:0]      i_base_addr,
    input  logic [4:0]      i_index_addr,
    input  logic [4:0]      i_data_addr,
    input  t_reg_wr         i_wr,
    output logic [XLEN-1:0] o_base,
    output logic [XLEN-1:0] o_index,
    output logic [XLEN-1:0] o_data
);

    logic [XLEN-1:0] r_mem_a [0:NUM_REGS-1];
    logic [XLEN-1:0] r_mem_b [0:NUM_REGS-1];

    logic [XLEN-1:0] r_rd_base;
    logic [XLEN-1:0] r_rd_index;
    logic [XLEN-1:0] r_rd_data;
    logic [4:0]      r_ra_base;
    logic [4:0]      r_ra_index;
    logic [4:0]      r_ra_data;

    logic [NUM_REGS-1:0] r_valid;
    logic                r_fw_valid;
    logic [4:0]          r_fw_addr;
    logic [XLEN-1:0]     r_fw_data;

    // Both copies take every write; reads see the old value on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_a[i_wr.addr] <= i_wr.data;
            r_mem_b[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_base  <= r_mem_a[i_base_addr];
            r_rd_index <= r_mem_a[i_index_addr];
            r_rd_data  <= r_mem_b[i_data_addr];
            r_ra_base  <= i_base_addr;
            r_ra_index <= i_index_addr;
            r_ra_data  <= i_data_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fw_valid <= 1'b0;
            r_fw_addr  <= '0;
            r_fw_data  <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
            r_fw_valid         <= 1'b1;
            r_fw_addr          <= i_wr.addr;
            r_fw_data          <= i_wr.data;
        end
    end

    // Resolve: zero register, then last write, then memory if ever written
    always_comb begin
        if (r_ra_base == ZERO_REG) begin
            o_base = '0;
        end else if (r_fw_valid && r_fw_addr == r_ra_base) begin
            o_base = r_fw_data;
        end else if (r_valid[r_ra_base]) begin
            o_base = r_rd_base;
        end else begin
            o_base = '0;
        end

        if (r_ra_index == ZERO_REG) begin
            o_index = '0;
        end else if (r_fw_valid && r_fw_addr == r_ra_index) begin
            o_index = r_fw_data;
        end else if (r_valid[r_ra_index]) begin
            o_index = r_rd_index;
        end else begin
            o_index = '0;
        end

        if (r_ra_data == ZERO_REG) begin
            o_data = '0;
        end else if (r_fw_valid && r_fw_addr == r_ra_data) begin
            o_data = r_fw_data;
        end else if (r_valid[r_ra_data]) begin
            o_data = r_rd_data;
        end else begin
            o_data = '0;
        end
    end

endmodule

FILE: hdl/lsau_exec.sv
// Execute stage: decode, address add, writeback selection and the pending-load record.
// Uses lsau_pkg; fed by lsau_regfile read data.
module lsau_exec
    import lsau_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  t_item           i_item,
    input  logic [XLEN-1:0] i_base,
    input  logic [XLEN-1:0] i_index,
    input  logic [XLEN-1:0] i_data,
    output t_result         o_result,
    output t_reg_wr         o_wr
);

    logic [4:0] r_pend_dest;
    logic       r_pend_wide;
    logic       r_pend_valid;
    logic [4:0] n_pend_dest;
    logic       n_pend_wide;
    logic       n_pend_valid;

    logic [31:0]     w;
    logic            sf;
    logic            base_form;
    logic            is_indexed;
    logic            is_load;
    logic            sp_base;
    logic [XLEN-1:0] imm_scaled;
    logic [XLEN-1:0] simm9;
    logic [XLEN-1:0] lit_off;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;
    logic [XLEN-1:0] sum;
    logic [XLEN-1:0] store_src;
    logic [XLEN-1:0] store_data;
    t_reg_wr         wr;

    always_comb begin
        w          = i_item.word;
        sf         = w[30];
        base_form  = w[31];
        is_indexed = base_form && !w[24] && !w[21];
        is_load    = base_form ? w[22] : 1'b1;
        sp_base    = base_form && (w[9:5] == ZERO_REG);
        imm_scaled = sf ? {49'd0, w[21:10], 3'b000} : {50'd0, w[21:10], 2'b00};
        simm9      = {{55{w[20]}}, w[20:12]};
        lit_off    = {{43{w[23]}}, w[23:5], 2'b00};

        op_a = base_form ? i_base : i_item.pc;
        if (!base_form) begin
            op_b = lit_off;
        end else if (w[24]) begin
            op_b = imm_scaled;
        end else if (!w[21]) begin
            op_b = simm9;
        end else begin
            op_b = i_index;
        end
        sum = op_a + op_b;

        // a store through its own indexed base sends the written-back base
        store_src  = (is_indexed && (w[4:0] == w[9:5])) ? sum : i_data;
        store_data = sf ? store_src : {32'd0, store_src[31:0]};

        o_result     = '0;
        wr           = '0;
        n_pend_dest  = r_pend_dest;
        n_pend_wide  = r_pend_wide;
        n_pend_valid = r_pend_valid;

        case (i_item.action)
            ACT_EXEC: begin
                if (sp_base) begin
                    o_result.unsup = 1'b1;
                end else begin
                    // post-index uses the old base, writes back base plus offset
                    o_result.addr = (is_indexed && !w[11]) ? i_base : sum;
                    o_result.wide = sf;
                    if (is_load) begin
                        o_result.kind = KIND_MEM_RD;
                        n_pend_dest   = w[4:0];
                        n_pend_wide   = sf;
                        n_pend_valid  = 1'b1;
                    end else begin
                        o_result.kind = KIND_MEM_WR;
                        o_result.data = store_data;
                    end
                    if (is_indexed) begin
                        wr.en   = 1'b1;
                        wr.addr = w[9:5];
                        wr.data = sum;
                    end
                end
            end
            ACT_RETURN: begin
                if (r_pend_valid) begin
                    wr.en        = (r_pend_dest != ZERO_REG);
                    wr.addr      = r_pend_dest;
                    wr.data      = r_pend_wide ? i_item.ret_data
                                               : {32'd0, i_item.ret_data[31:0]};
                    n_pend_valid = 1'b0;
                end
            end
            ACT_WRITE: begin
                wr.en   = (i_item.sel != ZERO_REG);
                wr.addr = i_item.sel;
                wr.data = i_item.wr_value;
            end
            ACT_READ: begin
                o_result.kind = KIND_REG_RPL;
                o_result.data = i_data;
            end
            default: begin
                o_result = '0;
            end
        endcase

        o_wr    = wr;
        o_wr.en = wr.en && i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_dest  <= '0;
            r_pend_wide  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_fire) begin
            r_pend_dest  <= n_pend_dest;
            r_pend_wide  <= n_pend_wide;
            r_pend_valid <= n_pend_valid;
        end
    end

endmodule

FILE: hdl/load_store_address_unit.sv
// Load/store address unit top level: handshakes, execute-stage register and output register.
// Depends on lsau_pkg, lsau_regfile and lsau_exec.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item per transfer: an
//   instruction to execute, a load-data return, a register write or a register
//   read. Output channel (o_out_valid / i_out_ready) carries exactly one result
//   per input item, in order.
//   Path: the item passes the execute-stage register, then the output register,
//   before o_out_valid rises. The register file read (synchronous memory,
//   registered read) is addressed straight from the input ports and lands at
//   the transfer edge; the execute stage resolves the read data, runs the single
//   64-bit address add, and on advancing writes back and loads the output register.
//   Throughput: one item per cycle while the receiver keeps i_out_ready high. A
//   write in the execute stage is forwarded to the following item, so dependent items issue back to back.
//   Reset: all registers read as zero, no load is pending, both stages empty.
//   Stall: when the receiver holds i_out_ready low with a result waiting, the
//   execute stage holds its item and o_in_ready drops once that stage is full;
//   the unit never drops or repeats a transfer.
module load_store_address_unit
    import lsau_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_action,
    input  logic [31:0]     i_instruction_word,
    input  logic [63:0]     i_program_counter,
    input  logic [63:0]     i_returned_data,
    input  logic [4:0]      i_reg_select,
    input  logic [63:0]     i_reg_write_value,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_request_kind,
    output logic [63:0]     o_mem_address,
    output logic [63:0]     o_data_value,
    output logic            o_access_is_wide,
    output logic            o_unsupported
);

    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out;

    logic            in_fire;
    logic            s1_fire;
    logic [4:0]      data_addr;
    logic [XLEN-1:0] rd_base;
    logic [XLEN-1:0] rd_index;
    logic [XLEN-1:0] rd_data;
    t_result         result;
    t_reg_wr         reg_wr;

    // Advance the execute stage whenever the output register is free or draining
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // Third read port serves store data (rt) or the register-read reply
    assign data_addr = (i_action == ACT_READ) ? i_reg_select : i_instruction_word[4:0];

    lsau_regfile u_regfile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (in_fire),
        .i_base_addr  (i_instruction_word[9:5]),
        .i_index_addr (i_instruction_word[20:16]),
        .i_data_addr  (data_addr),
        .i_wr         (reg_wr),
        .o_base       (rd_base),
        .o_index      (rd_index),
        .o_data       (rd_data)
    );

    lsau_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1_item),
        .i_base   (rd_base),
        .i_index  (rd_index),
        .i_data   (rd_data),
        .o_result (result),
        .o_wr     (reg_wr)
    );

    // Stage and output valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the item on transfer and the result when the execute stage advances, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.action   <= i_action;
            r_s1_item.word     <= i_instruction_word;
            r_s1_item.pc       <= i_program_counter;
            r_s1_item.ret_data <= i_returned_data;
            r_s1_item.sel      <= i_reg_select;
            r_s1_item.wr_value <= i_reg_write_value;
        end
        if (s1_fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_request_kind   = r_out.kind;
    assign o_mem_address    = r_out.addr;
    assign o_data_value     = r_out.data;
    assign o_access_is_wide = r_out.wide;
    assign o_unsupported    = r_out.unsup;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for load_store_address_unit: a scoreboard class keeps its own
// register file and pending load, predicts each transfer's result and checks the outputs.
// Depends on lsau_pkg and the load_store_address_unit RTL.
module tb_top;
    import lsau_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned MAX_REPORTS  = 10;
    // Execute stage plus output register; allow extra slack for late results.
    localparam int unsigned DRAIN_CYCLES = 10;

    // Addressing forms of an execute item.
    typedef enum logic [2:0] {AM_UIMM, AM_PRE, AM_POST, AM_REG, AM_LIT} t_addr_mode;

    // Scoreboard: tracks the architectural state and the queue of results still owed.
    class access_ledger;
        logic [63:0]  xreg [NUM_REGS];
        logic [4:0]   load_dest;
        logic         load_wide;
        bit           load_open;
        t_result      awaited [$];
        int unsigned  mismatches;

        function new();
            foreach (xreg[i]) xreg[i] = '0;
            load_dest  = '0;
            load_wide  = 1'b0;
            load_open  = 1'b0;
            mismatches = 0;
        endfunction

        // Register 31 reads as zero and swallows writes.
        function logic [63:0] xget(logic [4:0] r);
            return (r == ZERO_REG) ? '0 : xreg[r];
        endfunction

        function void xput(logic [4:0] r, logic [63:0] v);
            if (r != ZERO_REG) xreg[r] = v;
        endfunction

        // Predict the result of one accepted item and update the state it touches.
        function void log_item(t_item it);
            t_result     r;
            logic [31:0] w;
            logic [4:0]  xn;
            logic [63:0] base;
            logic [63:0] off9;
            logic [63:0] v;
            r    = '0;
            w    = it.word;
            xn   = w[9:5];
            case (it.action)
                ACT_EXEC: begin
                    if (w[31] && xn == ZERO_REG) begin
                        // stack-pointer base: flag it, touch nothing
                        r.unsup = 1'b1;
                    end else begin
                        if (!w[31]) begin
                            // literal: pc + simm19 * 4
                            r.addr = it.pc + {{43{w[23]}}, w[23:5], 2'b00};
                        end else begin
                            base = xget(xn);
                            off9 = {{55{w[20]}}, w[20:12]};
                            if (w[24]) begin
                                r.addr = base + (w[30] ? {49'd0, w[21:10], 3'b000}
                                                       : {50'd0, w[21:10], 2'b00});
                            end else if (!w[21]) begin
                                if (w[11]) begin
                                    r.addr = base + off9;
                                    xput(xn, r.addr);
                                end else begin
                                    r.addr = base;
                                    xput(xn, base + off9);
                                end
                            end else begin
                                r.addr = base + xget(w[20:16]);
                            end
                        end
                        r.wide = w[30];
                        if (!w[31] || w[22]) begin
                            r.kind    = KIND_MEM_RD;
                            load_dest = w[4:0];
                            load_wide = w[30];
                            load_open = 1'b1;
                        end else begin
                            // store data sees any base writeback done above
                            r.kind = KIND_MEM_WR;
                            r.data = xget(w[4:0]);
                            if (!w[30]) r.data[63:32] = '0;
                        end
                    end
                end
                ACT_RETURN: begin
                    if (load_open) begin
                        v = it.ret_data;
                        if (!load_wide) v[63:32] = '0;
                        xput(load_dest, v);
                        load_open = 1'b0;
                    end
                end
                ACT_WRITE: begin
                    xput(it.sel, it.wr_value);
                end
                ACT_READ: begin
                    r.kind = KIND_REG_RPL;
                    r.data = xget(it.sel);
                end
                default: begin
                end
            endcase
            awaited.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void match_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind=%0d addr=%h data=%h wide=%0b unsup=%0b",
                             got.kind, got.addr, got.data, got.wide, got.unsup);
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.addr !== want.addr || got.data !== want.data ||
                got.wide !== want.wide || got.unsup !== want.unsup) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: exp kind=%0d addr=%h data=%h wide=%0b unsup=%0b",
                             want.kind, want.addr, want.data, want.wide, want.unsup,
                             " | act kind=%0d addr=%h data=%h wide=%0b unsup=%0b",
                             got.kind, got.addr, got.data, got.wide, got.unsup);
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_ready;
    logic [1:0]   i_action;
    logic [31:0]  i_instruction_word;
    logic [63:0]  i_program_counter;
    logic [63:0]  i_returned_data;
    logic [4:0]   i_reg_select;
    logic [63:0]  i_reg_write_value;
    logic         o_out_valid;
    logic         i_out_ready;
    logic [1:0]   o_request_kind;
    logic [63:0]  o_mem_address;
    logic [63:0]  o_data_value;
    logic         o_access_is_wide;
    logic         o_unsupported;

    access_ledger ledger;
    bit           calm;        // high during the stretch with no idling on either side
    bit           in_fire;     // input transfer will happen at the coming rising edge
    t_result      seen;
    int unsigned  cycles = 0;

    load_store_address_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_instruction_word (i_instruction_word),
        .i_program_counter  (i_program_counter),
        .i_returned_data    (i_returned_data),
        .i_reg_select       (i_reg_select),
        .i_reg_write_value  (i_reg_write_value),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_request_kind     (o_request_kind),
        .o_mem_address      (o_mem_address),
        .o_data_value       (o_data_value),
        .o_access_is_wide   (o_access_is_wide),
        .o_unsupported      (o_unsupported)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle with a chance of about 15 percent, except during the calm stretch.
    function automatic bit roll_idle();
        return !calm && ($urandom_range(99) < 15);
    endfunction

    // Favor boundary values so address adds wrap and narrow accesses truncate.
    function automatic logic [63:0] rand64();
        case ($urandom_range(7))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return 64'h0000_0000_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Base register: mostly a real register, now and then the stack pointer.
    function automatic logic [4:0] pick_base();
        return ($urandom_range(15) == 0) ? ZERO_REG : 5'($urandom_range(30));
    endfunction

    // Build an execute word of the given form; leave the offset bits random.
    function automatic logic [31:0] make_word(t_addr_mode mode, logic load, logic sf,
                                              logic [4:0] rt, logic [4:0] xn);
        logic [31:0] w;
        w       = $urandom;
        w[4:0]  = rt;
        w[30]   = sf;
        if (mode == AM_LIT) begin
            w[31] = 1'b0;
        end else begin
            w[31]  = 1'b1;
            w[22]  = load;
            w[9:5] = xn;
            w[24]  = (mode == AM_UIMM);
            if (mode != AM_UIMM) begin
                w[21] = (mode == AM_REG);
                if (mode != AM_REG) w[11] = (mode == AM_PRE);
            end
        end
        return w;
    endfunction

    // Start from random content so fields the action ignores still toggle.
    function automatic t_item blank_item(logic [1:0] act);
        t_item it;
        it.action   = act;
        it.word     = $urandom;
        it.pc       = {$urandom, $urandom};
        it.ret_data = {$urandom, $urandom};
        it.sel      = 5'($urandom_range(30));
        it.wr_value = {$urandom, $urandom};
        return it;
    endfunction

    // Present one item and hold it until the transfer; log it with the scoreboard.
    task automatic send(input t_item it);
        while (roll_idle()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_action           <= it.action;
        i_instruction_word <= it.word;
        i_program_counter  <= it.pc;
        i_returned_data    <= it.ret_data;
        i_reg_select       <= it.sel;
        i_reg_write_value  <= it.wr_value;
        @(posedge i_clk);
        while (!in_fire) @(posedge i_clk);
        ledger.log_item(it);
    endtask

    task automatic do_exec(input logic [31:0] w, input logic [63:0] pc);
        t_item it;
        it      = blank_item(ACT_EXEC);
        it.word = w;
        it.pc   = pc;
        send(it);
    endtask

    task automatic do_return(input logic [63:0] v);
        t_item it;
        it          = blank_item(ACT_RETURN);
        it.ret_data = v;
        send(it);
    endtask

    task automatic do_write(input logic [4:0] r, input logic [63:0] v);
        t_item it;
        it          = blank_item(ACT_WRITE);
        it.sel      = r;
        it.wr_value = v;
        send(it);
    endtask

    task automatic do_read(input logic [4:0] r);
        t_item it;
        it     = blank_item(ACT_READ);
        it.sel = r;
        send(it);
    endtask

    // Sample handshakes at the falling edge, where everything driven at the
    // rising edge has settled and holds until the next transfer edge.
    always @(negedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.kind  = o_request_kind;
            seen.addr  = o_mem_address;
            seen.data  = o_data_value;
            seen.wide  = o_access_is_wide;
            seen.unsup = o_unsupported;
            ledger.match_result(seen);
        end
    end

    // Stall the result channel at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !roll_idle();
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned counted;
        int unsigned pick;
        logic [31:0] w;
        ledger             = new();
        calm               = 1'b0;
        in_fire            = 1'b0;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_out_ready        = 1'b0;
        i_action           = ACT_EXEC;
        i_instruction_word = '0;
        i_program_counter  = '0;
        i_returned_data    = '0;
        i_reg_select       = '0;
        i_reg_write_value  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corner cases first.
        do_return('1);                              // no load pending: ignored
        do_read(5'd0);                              // zero after reset
        do_write(5'd1, 64'hFFFF_FFFF_FFFF_FFF0);
        do_write(5'd2, 64'h8000_0000_0000_0000);
        do_write(5'd30, 64'hDEAD_BEEF_0123_4567);
        do_read(5'd30);
        // wide store, largest scaled imm12, address wraps
        w = make_word(AM_UIMM, 1'b0, 1'b1, 5'd30, 5'd1);
        w[21:10] = 12'hFFF;
        do_exec(w, rand64());
        // narrow store, upper store data cleared
        w = make_word(AM_UIMM, 1'b0, 1'b0, 5'd30, 5'd2);
        w[21:10] = 12'h000;
        do_exec(w, rand64());
        // pre-index load, most negative simm9, base writeback
        w = make_word(AM_PRE, 1'b1, 1'b1, 5'd3, 5'd1);
        w[20:12] = 9'h100;
        do_exec(w, rand64());
        do_return(64'h0123_4567_89AB_CDEF);
        // post-index store of the zero register, largest simm9
        w = make_word(AM_POST, 1'b0, 1'b1, ZERO_REG, 5'd1);
        w[20:12] = 9'h0FF;
        do_exec(w, rand64());
        do_read(5'd1);
        // register offset with the zero register as offset
        w = make_word(AM_REG, 1'b1, 1'b0, 5'd4, 5'd2);
        w[20:16] = ZERO_REG;
        do_exec(w, rand64());
        // literal load replaces the pending one; most negative simm19 wraps below zero
        w = make_word(AM_LIT, 1'b1, 1'b0, 5'd5, 5'd0);
        w[23:5] = 19'h40000;
        do_exec(w, 64'd0);
        do_return('1);                              // zero-extended into x5
        do_read(5'd5);
        // register offset store, base plus offset wraps
        w = make_word(AM_REG, 1'b0, 1'b1, 5'd1, 5'd1);
        w[20:16] = 5'd2;
        do_exec(w, rand64());
        // literal load into the zero register, largest simm19 from the top address
        w = make_word(AM_LIT, 1'b1, 1'b1, ZERO_REG, 5'd0);
        w[23:5] = 19'h3FFFF;
        do_exec(w, '1);
        do_return(64'hFEDC_BA98_7654_3210);         // discarded
        // stack-pointer base, load and store
        do_exec(make_word(AM_UIMM, 1'b1, 1'b1, 5'd6, ZERO_REG), rand64());
        do_exec(make_word(AM_POST, 1'b0, 1'b0, 5'd6, ZERO_REG), rand64());
        do_read(5'd3);
        do_return(rand64());                        // nothing pending again

        // Random: mostly well-formed loads, stores and load/return pairs.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            calm = (counted >= 600) && (counted < 900);
            pick = $urandom_range(99);
            if (pick < 35) begin
                do_exec(make_word(t_addr_mode'($urandom_range(4)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 5'($urandom_range(31)), pick_base()),
                        rand64());
                counted++;
            end else if (pick < 50) begin
                // load followed straight away by its data
                do_exec(make_word(t_addr_mode'($urandom_range(4)), 1'b1,
                                  1'($urandom_range(1)), 5'($urandom_range(31)), pick_base()),
                        rand64());
                do_return(rand64());
                counted += 2;
            end else if (pick < 62) begin
                do_return(rand64());
                counted++;
            end else if (pick < 80) begin
                do_write(5'($urandom_range(30)), rand64());
                counted++;
            end else if (pick < 92) begin
                do_read(5'($urandom_range(30)));
                counted++;
            end else begin
                // noise: any encoding at all
                do_exec($urandom, rand64());
                counted++;
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/lsau_pkg.sv
hdl/lsau_regfile.sv
hdl/lsau_exec.sv
hdl/load_store_address_unit.sv
test/tb_top.sv
